// ===== src/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define BDQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequence is checked in the cycle after the trigger.
`define BDQ_ASSERT_NEXT(name, trig, cons, msg) \
  `BDQ_ASSERT(name, (trig) |=> (cons), msg)

`endif

// ===== src/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with search.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned CMD_WIDTH    = 3;
  localparam int unsigned CAP_WIDTH    = 7;
  localparam int unsigned FILL_WIDTH   = 7;
  localparam int unsigned STATUS_WIDTH = 2;

  // Capacity value after reset, before clamping to the store depth.
  localparam int unsigned CAP_RESET = 64;

  // Command codes as they arrive on the request channel.
  localparam logic [CMD_WIDTH-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_SEARCH     = 3'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_ERASE      = 3'd5;

  // Decoded operation handed from the front end to the execution side.
  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SEARCH,
    OP_ERASE,
    OP_NOP
  } op_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_EMPTY,
    STAT_NOT_FOUND
  } status_e;

  // Head of the request queue as seen by the execution side.
  typedef struct packed {
    logic valid;
    op_e  op;
  } req_ctl_t;

endpackage

// ===== src/bdq_front.sv =====
// Front end of the deque: request handshake, command decode and a two-entry queue.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_front import bdq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CMD_WIDTH-1:0]   cmd_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output req_ctl_t               req_o,
  output logic [VALUE_WIDTH-1:0] req_value_o,
  input  logic                   req_take_i
);

  function automatic op_e classify(input logic [CMD_WIDTH-1:0] cmd);
    op_e op;
    case (cmd)
      CMD_PUSH_BACK:  op = OP_PUSH_BACK;
      CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
      CMD_POP_FRONT:  op = OP_POP_FRONT;
      CMD_POP_BACK:   op = OP_POP_BACK;
      CMD_SEARCH:     op = OP_SEARCH;
      CMD_ERASE:      op = OP_ERASE;
      default:        op = OP_NOP;
    endcase
    return op;
  endfunction

  op_e                    q_op_q  [2];
  logic [VALUE_WIDTH-1:0] q_val_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = req_take_i && (cnt_q != 2'd0);

  assign wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
  assign cnt_d    = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_op_q[wr_ptr_q]  <= classify(cmd_i);
      q_val_q[wr_ptr_q] <= value_i;
    end
  end

  assign req_o.valid = (cnt_q != 2'd0);
  assign req_o.op    = q_op_q[rd_ptr_q];
  assign req_value_o = q_val_q[rd_ptr_q];

endmodule

// ===== src/bdq_back.sv =====
// Execution side of the deque: the row of entry cells, match logic and result register.
// Depends on bdq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_back import bdq_pkg::*; #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned CW         = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  req_ctl_t                req_i,
  input  logic [VALUE_WIDTH-1:0]  req_value_i,
  output logic                    req_take_o,
  input  logic [CW-1:0]           eff_cap_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic [VALUE_WIDTH-1:0]  popped_value_o,
  output logic                    popped_valid_o,
  output logic [FILL_WIDTH-1:0]   fill_count_o,
  output logic                    full_res_o,
  output logic [STATUS_WIDTH-1:0] status_o
);

  localparam int unsigned CIW   = $clog2(DEPTH);
  localparam int unsigned STEPS = $clog2(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e                 state_q;
  op_e                    op_q;
  logic [VALUE_WIDTH-1:0] arg_q;
  logic [DEPTH-1:0]       match_q;
  logic [DEPTH-1:0]       match_c;
  logic [DEPTH-1:0]       after_hit;
  logic [VALUE_WIDTH-1:0] cell_q [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_d [DEPTH];
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          cnt_m1;
  logic [CIW-1:0]         last_idx;

  logic                   out_valid_q;
  logic                   hit_q;
  logic [VALUE_WIDTH-1:0] pval_q;
  logic                   pvalid_q;
  logic [FILL_WIDTH-1:0]  fill_q;
  logic                   full_q;
  status_e                status_q;

  logic                   full, empty, out_free, is_assoc, op_q_assoc;
  logic                   start_simple, start_match, apply, load, hit_any;
  op_e                    cur_op;
  logic [VALUE_WIDTH-1:0] cur_val;
  logic                   res_hit, res_pvalid;
  logic [VALUE_WIDTH-1:0] res_pval;
  status_e                res_status;

  assign full       = (count_q >= eff_cap_i);
  assign empty      = (count_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_assoc   = (req_i.op == OP_SEARCH) || (req_i.op == OP_ERASE);
  assign op_q_assoc = (op_q == OP_SEARCH) || (op_q == OP_ERASE);

  assign start_simple = (state_q == S_IDLE) && req_i.valid && !is_assoc && out_free;
  assign start_match  = (state_q == S_IDLE) && req_i.valid && is_assoc;
  assign apply        = (state_q == S_APPLY) && out_free;
  assign load         = start_simple || apply;
  assign req_take_o   = start_simple || start_match;

  assign cur_op  = (state_q == S_APPLY) ? op_q : req_i.op;
  assign cur_val = (state_q == S_APPLY) ? arg_q : req_value_i;

  assign cnt_m1   = count_q - CW'(1);
  assign last_idx = cnt_m1[CIW-1:0];

  // Every cell compares against the broadcast value; only live entries count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_c[i] = (cell_q[i] == req_value_i) && (CW'(i) < count_q);
    end
  end

  // Marks the first match and every cell behind it (log-step prefix OR).
  always_comb begin
    after_hit = match_q;
    for (int s = 0; s < STEPS; s++) begin
      after_hit = after_hit | (after_hit << (1 << s));
    end
  end

  assign hit_any = |match_q;

  always_comb begin
    cell_d     = cell_q;
    count_d    = count_q;
    res_hit    = 1'b0;
    res_pval   = '0;
    res_pvalid = 1'b0;
    res_status = STAT_OK;
    if (load) begin
      case (cur_op)
        OP_PUSH_BACK: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CW'(i) == count_q) begin
                cell_d[i] = cur_val;
              end
            end
            count_d = count_q + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            cell_d[0] = cur_val;
            for (int i = 1; i < DEPTH; i++) begin
              cell_d[i] = cell_q[i-1];
            end
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else begin
            res_pval   = cell_q[0];
            res_pvalid = 1'b1;
            for (int i = 0; i < DEPTH - 1; i++) begin
              cell_d[i] = cell_q[i+1];
            end
            count_d = cnt_m1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res_status = STAT_EMPTY;
          end else begin
            res_pval   = cell_q[last_idx];
            res_pvalid = 1'b1;
            count_d    = cnt_m1;
          end
        end
        OP_SEARCH: begin
          res_hit = hit_any;
        end
        OP_ERASE: begin
          if (hit_any) begin
            res_hit = 1'b1;
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (after_hit[i]) begin
                cell_d[i] = cell_q[i+1];
              end
            end
            count_d = cnt_m1;
          end else begin
            res_status = STAT_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      pval_q      <= '0;
      pvalid_q    <= 1'b0;
      fill_q      <= '0;
      full_q      <= 1'b0;
      status_q    <= STAT_OK;
    end else begin
      count_q <= count_d;
      case (state_q)
        S_IDLE: begin
          if (start_match) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
        hit_q       <= res_hit;
        pval_q      <= res_pval;
        pvalid_q    <= res_pvalid;
        fill_q      <= FILL_WIDTH'(count_d);
        full_q      <= (count_d >= eff_cap_i);
        status_q    <= res_status;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    if (start_match) begin
      op_q    <= req_i.op;
      arg_q   <= req_value_i;
      match_q <= match_c;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign popped_value_o = pval_q;
  assign popped_valid_o = pvalid_q;
  assign fill_count_o   = fill_q;
  assign full_res_o     = full_q;
  assign status_o       = status_q;

  `BDQ_ASSERT(a_count_in_range, count_q <= CW'(DEPTH), "entry count exceeds depth")
  `BDQ_ASSERT(a_apply_is_assoc, (state_q == S_APPLY) |-> op_q_assoc, "apply holds a plain op")
  `BDQ_ASSERT_NEXT(a_count_only_on_load, !load, $stable(count_q), "entry count moved without a result")
  `BDQ_ASSERT_NEXT(a_load_shows_result, load, out_valid_q, "result register not loaded")

endmodule

// ===== src/bounded_deque_with_search.sv =====
// Top level of the bounded deque with associative search.
// Depends on bdq_pkg, bdq_front and bdq_back.
`timescale 1ns / 1ps

// Bounded deque of page numbers with search. Each request transaction carries
// a command (push back, push front, pop front, pop back, search, erase first
// match) and a value, and produces exactly one result transaction with the hit
// flag, the popped value and its valid bit, the fill count after the request,
// a full flag and a status code. Requests enter a two-entry queue in the front
// end, so new requests are taken while the execution side works or while a
// result waits on a stalled output. Pushes and pops execute from the idle
// state; for search and erase every entry cell first compares against the
// value and registers its match bit, then the apply state resolves the first
// match and, for erase, closes up the entries behind it. Sustained throughput
// is one request per cycle for pushes and pops while the output is not
// stalled; a search or erase holds off the next request until it is applied.
// The capacity register is written through its own valid/ready transaction
// channel, always ready; a capacity of zero acts as one and one above DEPTH
// acts as DEPTH. Lowering the capacity below the fill count drops nothing: the
// store reads as full until enough entries are removed. Write the capacity
// only while no request is outstanding.

module bounded_deque_with_search import bdq_pkg::*; #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Request channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_WIDTH-1:0]    cmd_i,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic [VALUE_WIDTH-1:0]  popped_value_o,
  output logic                    popped_valid_o,
  output logic [FILL_WIDTH-1:0]   fill_count_o,
  output logic                    full_res_o,
  output logic [STATUS_WIDTH-1:0] status_o,
  // Capacity register write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_WIDTH-1:0]    cfg_data_i
);

  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned CAPW    = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
  localparam int unsigned CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  // The clamped capacity is kept rather than the raw register value, so the
  // execution side compares the fill count against it directly.
  logic [CW-1:0]          eff_cap_q, eff_cap_d;
  req_ctl_t               req;
  logic [VALUE_WIDTH-1:0] req_value;
  logic                   req_take;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i == '0) begin
      eff_cap_d = CW'(1);
    end else if (CAPW'(cfg_data_i) > CAPW'(DEPTH)) begin
      eff_cap_d = CW'(DEPTH);
    end else begin
      eff_cap_d = CW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_cap_q <= CW'(CAP_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      eff_cap_q <= eff_cap_d;
    end
  end

  bdq_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .req_o       (req),
    .req_value_o (req_value),
    .req_take_i  (req_take)
  );

  bdq_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .req_value_i    (req_value),
    .req_take_o     (req_take),
    .eff_cap_i      (eff_cap_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .popped_value_o (popped_value_o),
    .popped_valid_o (popped_valid_o),
    .fill_count_o   (fill_count_o),
    .full_res_o     (full_res_o),
    .status_o       (status_o)
  );

endmodule
